// File: rtl/hprm_pkg.sv
// Shared constants for the hall sensor period rate meter.
`default_nettype none

package hprm_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int FRACTION_BITS = 8;
    localparam int RATE_WIDTH    = 28;
    localparam int CNT_WIDTH     = $clog2(RATE_WIDTH);

    localparam logic [RATE_WIDTH-1:0] RATE_ONE_HZ =
        RATE_WIDTH'(64'd1000000 << FRACTION_BITS);

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(RATE_WIDTH - 1);

    typedef enum logic {
        OP_LEVEL_CHANGE = 1'b0,
        OP_RATE_QUERY   = 1'b1
    } op_t;

endpackage

`default_nettype wire

// File: rtl/hall_period_rate_meter.sv
// Hall sensor rotation rate meter with a bit-serial period divider.
`default_nettype none

// Rotation rate meter for a hall sensor. Each input transfer is a pin level
// change or a rate query, both stamped with a free-running microsecond time.
// A level change equal to magnet_level sets the stored rate to
// (1000000 << 8) / (time since the previous magnet edge) and records the
// edge time; other levels are dropped and produce no output. A query returns
// the smaller of the stored rate and the rate an edge arriving now would
// give, as unsigned fixed point with 8 fraction bits (revolutions per
// second), saturated at 256000000 for a zero interval. A magnet edge or a
// query is accepted in the idle state, then runs through the shared
// restoring divider and a finish state; in_ready stays low until it is back
// in idle. A zero interval skips the divider and goes straight to the finish
// state; an ignored level change leaves the meter idle. A finished query
// result waits in the output register, and the next item may be accepted
// meanwhile; a query that finishes while an earlier result still waits holds
// in the finish state, with in_ready low, until out_ready takes that result.
// magnet_level is written through the cfg channel, which is always ready.
module hall_period_rate_meter (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire                                   magnet_level,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   op,
    input  wire                                   pin_level,
    input  wire  [hprm_pkg::TIME_WIDTH-1:0]       event_time_us,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [hprm_pkg::RATE_WIDTH-1:0]       rate_fixed
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 magnet_level_reg, magnet_level_next;
    logic [hprm_pkg::TIME_WIDTH-1:0]      last_edge_time_reg, last_edge_time_next;
    logic [hprm_pkg::RATE_WIDTH-1:0]      rate_value_reg, rate_value_next;
    logic [hprm_pkg::TIME_WIDTH-1:0]      dt_reg, dt_next;
    logic [hprm_pkg::TIME_WIDTH-1:0]      rem_reg, rem_next;
    logic [hprm_pkg::RATE_WIDTH-1:0]      quo_reg, quo_next;
    logic [hprm_pkg::CNT_WIDTH-1:0]       cnt_reg, cnt_next;
    logic                                 is_query_reg, is_query_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [hprm_pkg::RATE_WIDTH-1:0]      rate_fixed_reg, rate_fixed_next;

    logic                                 in_xfer;
    logic                                 is_edge;
    logic                                 is_query;
    logic [hprm_pkg::TIME_WIDTH-1:0]      dt_now;
    logic [hprm_pkg::TIME_WIDTH:0]        rem_shift;
    logic [hprm_pkg::TIME_WIDTH:0]        rem_diff;
    logic                                 out_free;
    logic [hprm_pkg::RATE_WIDTH-1:0]      bounded_rate;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rate_fixed = rate_fixed_reg;

    assign in_xfer  = in_valid && in_ready;
    assign is_query = (op == hprm_pkg::OP_RATE_QUERY);
    assign is_edge  = (op == hprm_pkg::OP_LEVEL_CHANGE) && (pin_level == magnet_level_reg);
    assign dt_now   = event_time_us - last_edge_time_reg;

    assign rem_shift = {rem_reg, quo_reg[hprm_pkg::RATE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dt_reg};

    assign out_free     = !out_valid_reg || out_ready;
    assign bounded_rate = (rate_value_reg < quo_reg) ? rate_value_reg : quo_reg;

    always_comb
    begin
        state_next          = state_reg;
        magnet_level_next   = magnet_level_reg;
        last_edge_time_next = last_edge_time_reg;
        rate_value_next     = rate_value_reg;
        dt_next             = dt_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        cnt_next            = cnt_reg;
        is_query_next       = is_query_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        rate_fixed_next     = rate_fixed_reg;

        if (cfg_valid)
        begin
            magnet_level_next = magnet_level;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (is_query || is_edge))
                begin
                    dt_next       = dt_now;
                    rem_next      = '0;
                    quo_next      = hprm_pkg::RATE_ONE_HZ;
                    cnt_next      = '0;
                    is_query_next = is_query;
                    if (!is_query)
                    begin
                        last_edge_time_next = event_time_us;
                    end
                    // Zero interval saturates: quotient already holds the full rate.
                    state_next = (dt_now == '0) ? ST_FINISH : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!rem_diff[hprm_pkg::TIME_WIDTH])
                begin
                    rem_next = rem_diff[hprm_pkg::TIME_WIDTH-1:0];
                end
                else
                begin
                    rem_next = rem_shift[hprm_pkg::TIME_WIDTH-1:0];
                end
                quo_next = {quo_reg[hprm_pkg::RATE_WIDTH-2:0], !rem_diff[hprm_pkg::TIME_WIDTH]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hprm_pkg::CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!is_query_reg)
                begin
                    rate_value_next = quo_reg;
                    state_next      = ST_IDLE;
                end
                else if (out_free)
                begin
                    rate_fixed_next = bounded_rate;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            magnet_level_reg   <= 1'b0;
            last_edge_time_reg <= '0;
            rate_value_reg     <= '0;
            out_valid_reg      <= 1'b0;
            cnt_reg            <= '0;
            is_query_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            magnet_level_reg   <= magnet_level_next;
            last_edge_time_reg <= last_edge_time_next;
            rate_value_reg     <= rate_value_next;
            out_valid_reg      <= out_valid_next;
            cnt_reg            <= cnt_next;
            is_query_reg       <= is_query_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg         <= dt_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        rate_fixed_reg <= rate_fixed_next;
    end

    a_rate_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rate_value_reg <= hprm_pkg::RATE_ONE_HZ)
        else $error("stored rate above saturation");

    a_out_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> rate_fixed_reg <= hprm_pkg::RATE_ONE_HZ)
        else $error("output rate above saturation");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> cnt_reg <= hprm_pkg::CNT_LAST)
        else $error("divider count out of range");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && (cnt_reg == hprm_pkg::CNT_LAST) |=> state_reg == ST_FINISH)
        else $error("divider did not finish");

    a_ignored_level: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !is_query && !is_edge |=> state_reg == ST_IDLE && $stable(rate_value_reg))
        else $error("ignored level change altered state");

endmodule

`default_nettype wire

// File: bench/hprm_checker.sv
// Checker for the hall period rate meter: predicts each query's rate and compares results.
`timescale 1ns / 100ps

module hprm_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire                             magnet_level,
    input  wire                             in_valid,
    input  wire                             in_ready,
    input  wire                             op,
    input  wire                             pin_level,
    input  wire  [hprm_pkg::TIME_WIDTH-1:0] event_time_us,
    input  wire                             out_valid,
    input  wire                             out_ready,
    input  wire  [hprm_pkg::RATE_WIDTH-1:0] rate_fixed,
    output int                              errors,
    output int                              pending
);

    logic                            magnet_sel;
    logic [hprm_pkg::TIME_WIDTH-1:0] edge_time;
    logic [hprm_pkg::RATE_WIDTH-1:0] held_rate;
    logic [hprm_pkg::RATE_WIDTH-1:0] want;
    logic [hprm_pkg::RATE_WIDTH-1:0] bound;
    logic [hprm_pkg::RATE_WIDTH-1:0] rate_queue[$];

    function automatic logic [hprm_pkg::RATE_WIDTH-1:0] rate_since_edge(
        input logic [hprm_pkg::TIME_WIDTH-1:0] now_us);
        logic [hprm_pkg::TIME_WIDTH-1:0] period;
        period = now_us - edge_time;
        if (period == '0)
            return hprm_pkg::RATE_ONE_HZ;
        return hprm_pkg::RATE_WIDTH'(64'(hprm_pkg::RATE_ONE_HZ) / 64'(period));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnet_sel = 1'b0;
            edge_time  = '0;
            held_rate  = '0;
            rate_queue.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rate_queue.size() == 0)
                begin
                    $display("%0t: rate_fixed expected none actual %0d", $time, rate_fixed);
                    errors++;
                end
                else
                begin
                    want = rate_queue.pop_front();
                    if (rate_fixed !== want)
                    begin
                        $display("%0t: rate_fixed expected %0d actual %0d",
                                 $time, want, rate_fixed);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (op == hprm_pkg::OP_RATE_QUERY)
                begin
                    bound = rate_since_edge(event_time_us);
                    rate_queue.push_back(held_rate < bound ? held_rate : bound);
                end
                else if (pin_level == magnet_sel)
                begin
                    held_rate = rate_since_edge(event_time_us);
                    edge_time = event_time_us;
                end
            end
            if (cfg_valid && cfg_ready)
                magnet_sel = magnet_level;
            pending = rate_queue.size();
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top for the hall period rate meter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD   = 2;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 120;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            magnet_level;
    logic                            in_valid;
    logic                            in_ready;
    logic                            op;
    logic                            pin_level;
    logic [hprm_pkg::TIME_WIDTH-1:0] event_time_us;
    logic                            out_valid;
    logic                            out_ready;
    logic [hprm_pkg::RATE_WIDTH-1:0] rate_fixed;

    int                              errors;
    int                              pending;
    int                              quiet_cycles;
    int                              hold_requests;
    int                              holds_done;
    int                              burst_left;
    int                              stretch_left;
    ready_mode_t                     ready_mode;
    logic                            magnet_now;
    logic [hprm_pkg::TIME_WIDTH-1:0] clock_us;

    hall_period_rate_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .magnet_level  (magnet_level),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .pin_level     (pin_level),
        .event_time_us (event_time_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rate_fixed    (rate_fixed)
    );

    hprm_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .magnet_level  (magnet_level),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .pin_level     (pin_level),
        .event_time_us (event_time_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rate_fixed    (rate_fixed),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        out_ready    = 1'b0;
        holds_done   = 0;
        stretch_left = 0;
        ready_mode   = READY_ALWAYS;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(10, 200);
                ready_mode   = ready_mode_t'($urandom_range(0, 2));
            end
            stretch_left--;
            case (ready_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:      out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic offer(input hprm_pkg::op_t kind, input logic lvl,
                         input logic [hprm_pkg::TIME_WIDTH-1:0] stamp);
        op            <= kind;
        pin_level     <= lvl;
        event_time_us <= stamp;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_magnet(input logic lvl);
        drain();
        cfg_valid    <= 1'b1;
        magnet_level <= lvl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        magnet_now = lvl;
    endtask

    task automatic random_item(output bit counted);
        logic [hprm_pkg::TIME_WIDTH-1:0] step;
        int unsigned                     pick;
        logic                            lvl;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            step = '0;
        else if (pick < 28)
            step = $urandom_range(1, 300);
        else if (pick < 75)
            step = $urandom_range(300, 200000);
        else if (pick < 92)
            step = $urandom_range(200000, 5000000);
        else
            step = $urandom;
        clock_us += step;
        if ($urandom_range(0, 19) == 0)
            clock_us = $urandom;
        if ($urandom_range(0, 99) < 40)
        begin
            offer(hprm_pkg::OP_RATE_QUERY, 1'($urandom_range(0, 1)), clock_us);
            counted = 1'b1;
        end
        else
        begin
            lvl = ($urandom_range(0, 99) < 65) ? magnet_now : ~magnet_now;
            offer(hprm_pkg::OP_LEVEL_CHANGE, lvl, clock_us);
            counted = (lvl == magnet_now);
        end
    endtask

    // fill the result path while the receiver holds off
    task automatic squeeze_output();
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 10; i++)
        begin
            clock_us += $urandom_range(0, 5000);
            offer(hprm_pkg::OP_RATE_QUERY, 1'($urandom_range(0, 1)), clock_us);
        end
    endtask

    task automatic random_phase(input int count, input bit with_hold);
        int done;
        bit counted;
        done = 0;
        while (done < count)
        begin
            if (with_hold && done == count / 2)
            begin
                squeeze_output();
                done += 10;
            end
            random_item(counted);
            if (counted)
                done++;
            pace();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        magnet_level  = 1'b0;
        in_valid      = 1'b0;
        op            = hprm_pkg::OP_LEVEL_CHANGE;
        pin_level     = 1'b0;
        event_time_us = '0;
        hold_requests = 0;
        burst_left    = 0;
        magnet_now    = 1'b0;
        clock_us      = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'h0000_0000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b1, 32'hFFFF_FFFF);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b1, 32'h0000_0064);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'h0000_0000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'h0000_0000);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'h0000_0001);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b1, 32'h0000_0001);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'h0000_0003);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'hFFFF_FFFF);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'd999);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'd1002);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b1, 32'd1000999);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b1, 32'd2000000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'h7FFF_FFFF);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'h8000_0000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b1, 32'h8000_0007);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'h8000_0007);

        set_magnet(1'b1);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b0, 32'h8000_1000);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b1, 32'h8000_1000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b0, 32'h8000_1000);
        offer(hprm_pkg::OP_LEVEL_CHANGE, 1'b1, 32'h8000_2000);
        offer(hprm_pkg::OP_RATE_QUERY,   1'b1, 32'h8000_2FFF);
        clock_us = 32'h8000_3000;

        random_phase(PHASE_ITEMS, 1'b0);
        set_magnet(1'b0);
        random_phase(PHASE_ITEMS, 1'b1);
        set_magnet(1'b1);
        random_phase(PHASE_ITEMS, 1'b0);
        set_magnet(1'b0);
        random_phase(PHASE_ITEMS, 1'b0);

        drain();
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
